### rtl/core/oas_pkg.sv
// ----------------------------------------------------------------------------
// oas_pkg
// shared constants for the ordered array store: opcodes, status codes and
// field widths of the request and result transactions
// ----------------------------------------------------------------------------
package oas_pkg;

  // default number of words in the store
  localparam int DEPTH_DEFAULT = 32;

  // request fields
  localparam int OPCODE_W   = 3;
  localparam int VALUE_W    = 32;
  localparam int POSITION_W = 6;
  localparam int REQ_W      = OPCODE_W + VALUE_W + POSITION_W;
  localparam int REQ_BYTES_W = ((REQ_W + 7) / 8) * 8;

  // result fields
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 6;
  localparam int COUNT_W  = 6;
  localparam int RES_W    = STATUS_W + FOUND_W + COUNT_W;
  localparam int RES_BYTES_W = ((RES_W + 7) / 8) * 8;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_MODIFY = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_FIND   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // found position when the word is absent (-1)
  localparam logic [FOUND_W-1:0] NOT_FOUND = 6'h3F;

endpackage

### rtl/core/ordered_array_store.sv
// ----------------------------------------------------------------------------
// ordered_array_store
// ordered store of signed 32-bit words with append, insert, remove, modify
// and find, built around one memory and a small walking sequencer
// ----------------------------------------------------------------------------
//
//  channel   direction  fields (lowest bit first)
//  s_axis    in         opcode[2:0] value[34:3] position[40:35], zero pad to 48
//  m_axis    out        status[1:0] found_position[7:2] count[13:8], zero pad to 16
//
//  append, modify, errors and unused opcodes pass from accept through the
//  decode and done steps to the result register; insert, remove and find walk
//  the store one entry per cycle over the single memory read port, so their
//  walk covers up to the count of stored words; the memory has one read and
//  one write port, and the sequencer returns to idle before the next accept
//  s_tready is high only while the sequencer is idle; one transaction at a time
//  a finished result waits in the output register while the next request
//  can already be accepted; the sequencer holds only if that register is full
//  rst is synchronous and clears the count and control state; the word
//  memory is not cleared, since no entry at or above the count is ever read
//
module ordered_array_store #(
  parameter int DEPTH = oas_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // opcode[2:0], value[34:3], position[40:35]
  input  logic [oas_pkg::REQ_BYTES_W-1:0] s_tdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // status[1:0], found_position[7:2], count[13:8]
  output logic [oas_pkg::RES_BYTES_W-1:0] m_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready
);

  // widths derived from the depth
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > oas_pkg::POSITION_W) ? CNT_W : oas_pkg::POSITION_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_LAST = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state, state_next;

  // latched request
  logic [oas_pkg::OPCODE_W-1:0]   opcode;
  logic signed [oas_pkg::VALUE_W-1:0] value;
  logic [oas_pkg::POSITION_W-1:0] position;

  // store state
  logic [CNT_W-1:0] used_count, used_count_next;
  logic [oas_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [oas_pkg::VALUE_W-1:0] rd_data;

  // walk pointer and the read in flight
  logic [CNT_W-1:0] ptr, ptr_next;
  logic             pend, pend_next;
  logic [AW-1:0]    pend_addr, pend_addr_next;

  // result being built
  logic [oas_pkg::STATUS_W-1:0] status, status_next;
  logic [oas_pkg::FOUND_W-1:0]  found, found_next;

  // memory port controls
  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [oas_pkg::VALUE_W-1:0] mem_wdata;

  logic [CMP_W-1:0] pos_ext, cnt_ext, idx_ext;
  logic [CNT_W-1:0] pos_c;
  logic [AW-1:0]    pos_a;
  logic             full;
  logic             issue;
  logic             s_accept;
  logic             out_free;

  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign pos_ext = CMP_W'(position);
  assign cnt_ext = CMP_W'(used_count);
  assign idx_ext = CMP_W'(pend_addr);
  // only used once the position is known to be within the count
  assign pos_c   = pos_ext[CNT_W-1:0];
  assign pos_a   = pos_ext[AW-1:0];
  assign full    = (used_count == DEPTH_C);

  // insert walks down from the count, remove and find walk up
  always_comb begin
    if (opcode == oas_pkg::OP_INSERT) begin
      issue = (ptr > pos_c);
    end else begin
      issue = (ptr < used_count);
    end
  end

  always_comb begin
    state_next      = state;
    used_count_next = used_count;
    ptr_next        = ptr;
    pend_next       = 1'b0;
    pend_addr_next  = pend_addr;
    status_next     = status;
    found_next      = found;
    mem_we          = 1'b0;
    mem_waddr       = pos_a;
    mem_wdata       = value;
    mem_re          = 1'b0;
    mem_raddr       = ptr[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (s_accept) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        status_next = oas_pkg::ST_OK;
        found_next  = oas_pkg::NOT_FOUND;
        state_next  = S_DONE;
        unique case (opcode)
          oas_pkg::OP_APPEND: begin
            if (full) begin
              status_next = oas_pkg::ST_FULL;
            end else begin
              mem_we          = 1'b1;
              mem_waddr       = used_count[AW-1:0];
              used_count_next = used_count + 1'b1;
            end
          end
          oas_pkg::OP_INSERT: begin
            // range check comes before the full check
            if (pos_ext > cnt_ext) begin
              status_next = oas_pkg::ST_RANGE;
            end else if (full) begin
              status_next = oas_pkg::ST_FULL;
            end else begin
              ptr_next   = used_count;
              state_next = S_WALK;
            end
          end
          oas_pkg::OP_REMOVE: begin
            if (pos_ext >= cnt_ext) begin
              status_next = oas_pkg::ST_RANGE;
            end else begin
              ptr_next   = CNT_W'(pos_c + 1'b1);
              state_next = S_WALK;
            end
          end
          oas_pkg::OP_MODIFY: begin
            if (pos_ext >= cnt_ext) begin
              status_next = oas_pkg::ST_RANGE;
            end else begin
              mem_we = 1'b1;
            end
          end
          oas_pkg::OP_FIND: begin
            ptr_next   = '0;
            state_next = S_WALK;
          end
          default: begin
            // unused opcodes leave everything as it is
          end
        endcase
      end

      S_WALK: begin
        // issue the next read of the walk
        if (issue) begin
          mem_re    = 1'b1;
          pend_next = 1'b1;
          if (opcode == oas_pkg::OP_INSERT) begin
            mem_raddr      = AW'(ptr - 1'b1);
            pend_addr_next = ptr[AW-1:0];
            ptr_next       = ptr - 1'b1;
          end else if (opcode == oas_pkg::OP_REMOVE) begin
            pend_addr_next = AW'(ptr - 1'b1);
            ptr_next       = ptr + 1'b1;
          end else begin
            pend_addr_next = ptr[AW-1:0];
            ptr_next       = ptr + 1'b1;
          end
        end

        // retire the read issued last cycle
        if (pend && opcode != oas_pkg::OP_FIND) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr;
          mem_wdata = rd_data;
        end

        if (pend && opcode == oas_pkg::OP_FIND && rd_data == value) begin
          found_next = idx_ext[oas_pkg::FOUND_W-1:0];
          state_next = S_DONE;
        end else if (!issue && !pend) begin
          if (opcode == oas_pkg::OP_INSERT) begin
            state_next = S_LAST;
          end else begin
            if (opcode == oas_pkg::OP_REMOVE) begin
              used_count_next = used_count - 1'b1;
            end
            state_next = S_DONE;
          end
        end
      end

      S_LAST: begin
        // gap is open, drop the new word in
        mem_we          = 1'b1;
        used_count_next = used_count + 1'b1;
        state_next      = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // word memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // request latch and walk registers
  always_ff @(posedge clk) begin
    if (s_accept) begin
      opcode   <= s_tdata[2:0];
      value    <= s_tdata[34:3];
      position <= s_tdata[40:35];
    end
    ptr       <= ptr_next;
    pend_addr <= pend_addr_next;
    status    <= status_next;
    found     <= found_next;
  end

  // control state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      pend       <= 1'b0;
      m_tvalid   <= 1'b0;
      m_tdata    <= '0;
    end else begin
      state      <= state_next;
      used_count <= used_count_next;
      pend       <= pend_next;
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {{(oas_pkg::RES_BYTES_W - oas_pkg::RES_W){1'b0}},
                     cnt_ext[oas_pkg::COUNT_W-1:0], found, status};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // the count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= DEPTH_C)
    else $error("word count beyond depth");

  // the count moves by at most one per request
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (used_count != $past(used_count)) |->
      (used_count == CNT_W'($past(used_count) + 1'b1) ||
       used_count == CNT_W'($past(used_count) - 1'b1)))
    else $error("word count jumped");

  // an accepted request is always taken up by the decode step
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> (state == S_EXEC))
    else $error("accepted request not decoded");

  // a new result only appears from the done step
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_DONE))
    else $error("result raised outside done step");

  // shifting writes during a walk always come from a read in flight
  a_walk_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && mem_we) |-> pend)
    else $error("walk write without read data");

endmodule

### test/ordered_array_store_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_store_checker
// watches both channels of the ordered array store, keeps its own copy of
// the stored words and the count, works out the result of every accepted
// request and compares each returned result against the oldest one waiting
// ----------------------------------------------------------------------------
module ordered_array_store_checker #(
  parameter int DEPTH = oas_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [oas_pkg::REQ_BYTES_W-1:0] s_tdata,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [oas_pkg::RES_BYTES_W-1:0] m_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  output int                              fail_count,
  output int                              pending,
  output int                              word_count
);

  typedef struct packed {
    logic [oas_pkg::STATUS_W-1:0]       status;
    logic signed [oas_pkg::FOUND_W-1:0] found_position;
    logic [oas_pkg::COUNT_W-1:0]        count;
  } store_result_t;

  store_result_t               expected_outcomes[$];
  logic [oas_pkg::VALUE_W-1:0] shadow_words[DEPTH];
  int                          used_words = 0;
  int                          mismatches = 0;

  // applies one request to the shadow store and returns what it should report
  function automatic store_result_t apply_request(
      input logic [oas_pkg::OPCODE_W-1:0]   op,
      input logic [oas_pkg::VALUE_W-1:0]    val,
      input logic [oas_pkg::POSITION_W-1:0] pos);
    store_result_t r;
    int            i;
    bit            hit;
    r.status         = oas_pkg::ST_OK;
    r.found_position = oas_pkg::NOT_FOUND;
    hit              = 1'b0;
    case (op)
      oas_pkg::OP_APPEND: begin
        if (used_words >= DEPTH) begin
          r.status = oas_pkg::ST_FULL;
        end else begin
          shadow_words[used_words] = val;
          used_words++;
        end
      end
      oas_pkg::OP_INSERT: begin
        // range check takes priority over the full check
        if (int'(pos) > used_words) begin
          r.status = oas_pkg::ST_RANGE;
        end else if (used_words >= DEPTH) begin
          r.status = oas_pkg::ST_FULL;
        end else begin
          for (i = used_words; i > int'(pos); i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[pos] = val;
          used_words++;
        end
      end
      oas_pkg::OP_REMOVE: begin
        if (int'(pos) >= used_words) begin
          r.status = oas_pkg::ST_RANGE;
        end else begin
          for (i = int'(pos); i + 1 < used_words; i++) shadow_words[i] = shadow_words[i+1];
          used_words--;
        end
      end
      oas_pkg::OP_MODIFY: begin
        if (int'(pos) >= used_words) begin
          r.status = oas_pkg::ST_RANGE;
        end else begin
          shadow_words[pos] = val;
        end
      end
      oas_pkg::OP_FIND: begin
        for (i = 0; i < used_words && !hit; i++) begin
          if (shadow_words[i] == val) begin
            r.found_position = i[oas_pkg::FOUND_W-1:0];
            hit              = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.count = used_words[oas_pkg::COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    store_result_t seen;
    store_result_t want;
    if (rst) begin
      used_words = 0;
      expected_outcomes.delete();
    end else begin
      // results first: a result can never belong to a request accepted this edge
      if (m_tvalid && m_tready) begin
        seen.status         = m_tdata[oas_pkg::STATUS_W-1:0];
        seen.found_position = m_tdata[oas_pkg::STATUS_W+oas_pkg::FOUND_W-1:oas_pkg::STATUS_W];
        seen.count          = m_tdata[oas_pkg::RES_W-1:oas_pkg::STATUS_W+oas_pkg::FOUND_W];
        if (expected_outcomes.size() == 0) begin
          $error("result with no request outstanding: status %0d found %0d count %0d",
                 seen.status, $signed(seen.found_position), seen.count);
          mismatches++;
        end else begin
          want = expected_outcomes.pop_front();
          if (seen.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, seen.status);
            mismatches++;
          end
          if (seen.found_position !== want.found_position) begin
            $error("found_position mismatch: expected %0d, actual %0d",
                   $signed(want.found_position), $signed(seen.found_position));
            mismatches++;
          end
          if (seen.count !== want.count) begin
            $error("count mismatch: expected %0d, actual %0d", want.count, seen.count);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        expected_outcomes.push_back(apply_request(
          s_tdata[oas_pkg::OPCODE_W-1:0],
          s_tdata[oas_pkg::OPCODE_W+oas_pkg::VALUE_W-1:oas_pkg::OPCODE_W],
          s_tdata[oas_pkg::REQ_W-1:oas_pkg::OPCODE_W+oas_pkg::VALUE_W]));
      end
    end
    fail_count <= mismatches;
    pending    <= expected_outcomes.size();
    word_count <= used_words;
  end

endmodule

### test/tb_ordered_array_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_array_store
// drives requests into the ordered array store and drains its results with
// random gaps and back-pressure; a directed opening covers the edge cases,
// then random phases fill, empty and churn the store while the checker
// module predicts and compares every result
// ----------------------------------------------------------------------------
module tb_ordered_array_store;

  localparam int DEPTH         = oas_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS  = 700;
  // watchdog limit on the total length of the run
  localparam int CYCLE_LIMIT   = 400000;
  // quiet time at the end, after all results are back
  localparam int SETTLE_CYCLES = 2 * (DEPTH + 4);

  // field widths used locally
  localparam int OP_W  = oas_pkg::OPCODE_W;
  localparam int VAL_W = oas_pkg::VALUE_W;
  localparam int POS_W = oas_pkg::POSITION_W;
  localparam int REQ_BYTES_W = oas_pkg::REQ_BYTES_W;
  localparam int RES_BYTES_W = oas_pkg::RES_BYTES_W;

  // opcodes the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  // value extremes
  localparam logic [VAL_W-1:0] VAL_MIN  = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_ZERO = 32'h0000_0000;

  localparam logic [POS_W-1:0] POS_TOP = '1;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [REQ_BYTES_W-1:0] s_tdata = '0;   // opcode, value, position, zero pad
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [RES_BYTES_W-1:0] m_tdata;        // status, found_position, count, zero pad
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;

  int fail_count;
  int pending;
  int word_count;
  int cycles = 0;
  int requests_sent = 0;      // unused opcodes are not counted
  bit idle_on = 1'b1;         // cleared for stretches with no gaps or stalls

  // recently written values, reused so that finds actually hit
  logic [VAL_W-1:0] recent_values[8] = '{default: '0};
  int               recent_slot = 0;

  always #4 clk = ~clk;

  ordered_array_store #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata (m_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready)
  );

  ordered_array_store_checker #(
    .DEPTH(DEPTH)
  ) checker_inst (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .fail_count(fail_count),
    .pending   (pending),
    .word_count(word_count)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall before each transaction, ready held until it goes
  initial begin : result_sink
    int stall;
    while (rst) @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // one request transaction; returns at the falling edge after the handshake
  // with valid still high, so back-to-back requests never drop valid
  task automatic send_request(input logic [OP_W-1:0]  op,
                              input logic [VAL_W-1:0] val,
                              input logic [POS_W-1:0] pos);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {{(REQ_BYTES_W-oas_pkg::REQ_W){1'b0}}, pos, val, op};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (op <= oas_pkg::OP_FIND) requests_sent++;
    if (op == oas_pkg::OP_APPEND || op == oas_pkg::OP_INSERT || op == oas_pkg::OP_MODIFY) begin
      recent_values[recent_slot] = val;
      recent_slot = (recent_slot + 1) % 8;
    end
  endtask

  // stop sending until every outstanding result has come back
  task automatic wait_for_results;
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // half the time a small pool of values so duplicates and find hits are common
  function automatic logic [VAL_W-1:0] pick_value;
    case ($urandom_range(0, 13))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return VAL_NEG1;
      3:       return VAL_ZERO;
      4:       return 32'd1;
      5:       return 32'h0000_0100;
      6:       return 32'hDEAD_BEEF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_search_value;
    if ($urandom_range(0, 4) < 3) return recent_values[$urandom_range(0, 7)];
    return pick_value();
  endfunction

  // valid position up to highest, biased to the ends, with some out-of-range noise
  function automatic logic [POS_W-1:0] pick_position(input int highest);
    if (highest < 0 || $urandom_range(0, 7) == 0) return POS_W'($urandom());
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return POS_W'(highest);
      default: return POS_W'($urandom_range(0, highest));
    endcase
  endfunction

  // general churn with every opcode
  task automatic churn_store(input int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 22)
        send_request(oas_pkg::OP_APPEND, pick_value(), POS_W'($urandom()));
      else if (pick < 42)
        send_request(oas_pkg::OP_INSERT, pick_value(), pick_position(word_count));
      else if (pick < 62)
        send_request(oas_pkg::OP_REMOVE, pick_value(), pick_position(word_count - 1));
      else if (pick < 72)
        send_request(oas_pkg::OP_MODIFY, pick_value(), pick_position(word_count - 1));
      else if (pick < 95)
        send_request(oas_pkg::OP_FIND, pick_search_value(), POS_W'($urandom()));
      else
        send_request(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), $urandom(),
                     POS_W'($urandom()));
    end
  endtask

  // grow the store to full, then push against the limit
  task automatic fill_store;
    int guard;
    guard = 0;
    while (word_count < DEPTH && guard < 3 * DEPTH) begin
      if ($urandom_range(0, 1) == 0)
        send_request(oas_pkg::OP_APPEND, pick_value(), POS_W'($urandom()));
      else
        send_request(oas_pkg::OP_INSERT, pick_value(), POS_W'($urandom_range(0, word_count)));
      guard++;
    end
    // full store: append refused, insert refused, bad insert position wins over full
    send_request(oas_pkg::OP_APPEND, pick_value(), '0);
    send_request(oas_pkg::OP_INSERT, pick_value(), POS_W'($urandom_range(0, word_count)));
    send_request(oas_pkg::OP_INSERT, pick_value(), POS_W'(word_count + 1));
    send_request(oas_pkg::OP_FIND, pick_search_value(), '0);
    send_request(oas_pkg::OP_MODIFY, pick_value(), POS_W'(word_count - 1));
    send_request(oas_pkg::OP_FIND, pick_search_value(), '0);
  endtask

  // remove down to empty with finds mixed in
  task automatic drain_store;
    int guard;
    guard = 0;
    while (word_count > 0 && guard < 3 * DEPTH) begin
      if ($urandom_range(0, 3) == 0)
        send_request(oas_pkg::OP_FIND, pick_search_value(), POS_W'($urandom()));
      else
        send_request(oas_pkg::OP_REMOVE, pick_value(),
                     POS_W'($urandom_range(0, word_count - 1)));
      guard++;
    end
    send_request(oas_pkg::OP_REMOVE, pick_value(), '0);
    send_request(oas_pkg::OP_FIND, pick_search_value(), '0);
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed opening, starting from an empty store
    send_request(oas_pkg::OP_FIND,   VAL_MIN,  '0);          // find in empty store
    send_request(oas_pkg::OP_REMOVE, VAL_ZERO, '0);          // remove from empty store
    send_request(oas_pkg::OP_MODIFY, VAL_MAX,  '0);          // modify in empty store
    send_request(oas_pkg::OP_INSERT, VAL_NEG1, 6'd1);        // insert past the end
    send_request(oas_pkg::OP_INSERT, VAL_MIN,  '0);
    send_request(oas_pkg::OP_APPEND, VAL_MAX,  POS_TOP);
    send_request(oas_pkg::OP_APPEND, VAL_NEG1, '0);
    send_request(oas_pkg::OP_INSERT, VAL_ZERO, 6'd3);        // insert exactly at the end
    send_request(oas_pkg::OP_INSERT, VAL_MAX,  '0);          // insert at the front
    send_request(oas_pkg::OP_FIND,   VAL_MAX,  POS_TOP);     // duplicate, first one wins
    send_request(oas_pkg::OP_FIND,   VAL_NEG1, '0);
    send_request(oas_pkg::OP_FIND,   32'h0000_1234, '0);     // absent value
    send_request(oas_pkg::OP_MODIFY, 32'h5555_5555, 6'd4);   // last word
    send_request(oas_pkg::OP_MODIFY, 32'hAAAA_AAAA, 6'd5);   // one past the last word
    send_request(oas_pkg::OP_REMOVE, VAL_ZERO, 6'd5);        // one past the last word
    send_request(oas_pkg::OP_REMOVE, VAL_ZERO, 6'd4);        // last word
    send_request(oas_pkg::OP_REMOVE, VAL_ZERO, '0);          // front word
    send_request(oas_pkg::OP_INSERT, VAL_NEG1, POS_TOP);     // highest position
    send_request(OP_SPARE_LO, VAL_NEG1, POS_TOP);
    send_request(3'd6,        VAL_MIN,  '0);                 // middle spare opcode
    send_request(OP_SPARE_HI, VAL_MAX,  POS_TOP);
    send_request(oas_pkg::OP_FIND,   32'hAAAA_AAAA, '0);
    wait_for_results();

    // random part: a fill first so full-store behaviour is always reached
    requests_sent = 0;
    fill_store();
    while (requests_sent < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1:    fill_store();
        2:       drain_store();
        default: churn_store($urandom_range(10, 40));
      endcase
      if ($urandom_range(0, 4) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
